### hdl/cscan_disk_request_scheduler_defines.svh
// ----------------------------------------------------------------------------
// C-SCAN scheduler assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off while in reset.
// ----------------------------------------------------------------------------
`ifndef CSCAN_DISK_REQUEST_SCHEDULER_DEFINES_SVH
`define CSCAN_DISK_REQUEST_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define CDRS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cdrs check failed");

// next-cycle implication
`define CDRS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cdrs check failed");

`endif

### hdl/cdrs_pkg.sv
// ----------------------------------------------------------------------------
// C-SCAN scheduler package
// Field widths, register port constants and the sequencer state type.
// ----------------------------------------------------------------------------
package cdrs_pkg;

    localparam int TRK_W   = 16;   // track field width
    localparam int TOT_W   = 18;   // running movement width
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    // paddr bit that selects a register beyond the single head register
    localparam int HEAD_SEL_BIT = 2;

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_INS_RD    = 9'b000000010,
        S_INS_CMP   = 9'b000000100,
        S_FIND_RD   = 9'b000001000,
        S_FIND_CMP  = 9'b000010000,
        S_EMIT_RD   = 9'b000100000,
        S_EMIT_CALC = 9'b001000000,
        S_WRAP      = 9'b010000000,
        S_OUT       = 9'b100000000
    } t_state;

endpackage

### hdl/cscan_disk_request_scheduler.sv
// ----------------------------------------------------------------------------
// C-SCAN disk request scheduler
// Collects a batch of track requests in sorted order, then emits the visit
// schedule: upper sweep ascending, wrap to track 0, lower sweep ascending.
// ----------------------------------------------------------------------------
// Load: a stored request walks down the sorted store, one read and one
//   compare per entry it moves past, and is written once it lands in its slot.
// Closing request: insertion, then a search for the first track above the
//   head, then a read, a calc and an output step per visit, a wrap step and
//   an output step for the wrap stop, plus output stalls.
// Ready only when idle. Sync active-low reset empties the batch, head = 0.
module cscan_disk_request_scheduler #(
    parameter int MAX_REQUESTS = 32,
    parameter int TRACK_BITS   = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [cdrs_pkg::TRK_W-1:0]        i_track,
    input  logic                              i_last,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [cdrs_pkg::TRK_W-1:0]        o_served_track,
    output logic                              o_wrap_stop,
    output logic [cdrs_pkg::TOT_W-1:0]        o_total_movement,
    output logic                              o_end_of_run,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cdrs_pkg::APB_AW-1:0]       paddr,
    input  logic [cdrs_pkg::APB_DW-1:0]       pwdata,
    output logic [cdrs_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);

    localparam int KW    = (TRACK_BITS < cdrs_pkg::TRK_W) ? TRACK_BITS : cdrs_pkg::TRK_W;
    localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REQUESTS);

    cdrs_pkg::t_state r_state, n_state;

    logic [CNT_W-1:0]           r_cnt, n_cnt;
    logic [CNT_W-1:0]           r_idx, n_idx;
    logic [CNT_W-1:0]           r_first, n_first;
    logic [KW-1:0]              r_new, n_new;
    logic                       r_last, n_last;
    logic                       r_upper, n_upper;
    logic [KW-1:0]              r_pos, n_pos;
    logic [cdrs_pkg::TOT_W-1:0] r_total, n_total;
    logic                       r_wrap, n_wrap;
    logic                       r_eor, n_eor;
    logic [cdrs_pkg::TRK_W-1:0] r_head;
    logic [KW-1:0]              r_rdata;

    // sorted request memory
    logic [KW-1:0]              mem [MAX_REQUESTS];
    logic                       w_we;
    logic [IDX_W-1:0]           w_waddr;
    logic [KW-1:0]              w_wdata;
    logic [IDX_W-1:0]           w_raddr;

    logic [KW-1:0]              w_start;
    logic [CNT_W-1:0]           w_idx_inc;
    logic [CNT_W-1:0]           w_idx_dec;
    logic [KW-1:0]              w_diff;
    logic [KW-1:0]              w_addend;
    logic [cdrs_pkg::TOT_W-1:0] w_sum;
    logic                       w_cfg_wr;

    assign w_start   = r_head[KW-1:0];
    assign w_idx_inc = r_idx + 1'b1;
    assign w_idx_dec = r_idx - 1'b1;

    // shared movement unit: |pos - track| on a visit, pos itself on the wrap
    assign w_diff   = (r_pos > r_rdata) ? (r_pos - r_rdata) : (r_rdata - r_pos);
    assign w_addend = (r_state == cdrs_pkg::S_WRAP) ? r_pos : w_diff;
    assign w_sum    = r_total + cdrs_pkg::TOT_W'(w_addend);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_first = r_first;
        n_new   = r_new;
        n_last  = r_last;
        n_upper = r_upper;
        n_pos   = r_pos;
        n_total = r_total;
        n_wrap  = r_wrap;
        n_eor   = r_eor;
        w_we    = 1'b0;
        w_waddr = r_idx[IDX_W-1:0];
        w_wdata = r_new;
        w_raddr = r_idx[IDX_W-1:0];
        case (r_state)
            cdrs_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_new  = i_track[KW-1:0];
                    n_last = i_last;
                    if (r_cnt < MAX_CNT) begin
                        n_idx   = r_cnt;
                        n_state = cdrs_pkg::S_INS_RD;
                    end else if (i_last) begin
                        // store full: item dropped, but it still closes the batch
                        n_idx   = '0;
                        n_state = cdrs_pkg::S_FIND_RD;
                    end
                end
            end
            cdrs_pkg::S_INS_RD: begin
                if (r_idx == '0) begin
                    w_we    = 1'b1;
                    n_cnt   = r_cnt + 1'b1;
                    n_idx   = '0;
                    n_state = r_last ? cdrs_pkg::S_FIND_RD : cdrs_pkg::S_IDLE;
                end else begin
                    w_raddr = w_idx_dec[IDX_W-1:0];
                    n_state = cdrs_pkg::S_INS_CMP;
                end
            end
            cdrs_pkg::S_INS_CMP: begin
                w_we = 1'b1;
                if (r_rdata > r_new) begin
                    // shift the larger entry up one slot
                    w_wdata = r_rdata;
                    n_idx   = w_idx_dec;
                    n_state = cdrs_pkg::S_INS_RD;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_idx   = '0;
                    n_state = r_last ? cdrs_pkg::S_FIND_RD : cdrs_pkg::S_IDLE;
                end
            end
            cdrs_pkg::S_FIND_RD: begin
                n_pos   = w_start;
                n_total = '0;
                if (r_idx == r_cnt) begin
                    // nothing above the head: straight to the wrap
                    n_first = r_cnt;
                    n_upper = 1'b0;
                    n_state = cdrs_pkg::S_WRAP;
                end else begin
                    n_state = cdrs_pkg::S_FIND_CMP;
                end
            end
            cdrs_pkg::S_FIND_CMP: begin
                if (r_rdata > w_start) begin
                    n_first = r_idx;
                    n_upper = 1'b1;
                    n_state = cdrs_pkg::S_EMIT_RD;
                end else begin
                    n_idx   = w_idx_inc;
                    n_state = cdrs_pkg::S_FIND_RD;
                end
            end
            cdrs_pkg::S_EMIT_RD: begin
                n_state = cdrs_pkg::S_EMIT_CALC;
            end
            cdrs_pkg::S_EMIT_CALC: begin
                n_total = w_sum;
                n_pos   = r_rdata;
                n_wrap  = 1'b0;
                n_eor   = !r_upper && (w_idx_inc == r_first);
                n_state = cdrs_pkg::S_OUT;
            end
            cdrs_pkg::S_WRAP: begin
                n_total = w_sum;
                n_pos   = '0;
                n_wrap  = 1'b1;
                n_eor   = (r_first == '0);
                n_state = cdrs_pkg::S_OUT;
            end
            cdrs_pkg::S_OUT: begin
                if (i_ready) begin
                    if (r_eor) begin
                        n_cnt   = '0;
                        n_state = cdrs_pkg::S_IDLE;
                    end else if (r_wrap) begin
                        n_idx   = '0;
                        n_upper = 1'b0;
                        n_state = cdrs_pkg::S_EMIT_RD;
                    end else if (r_upper && (w_idx_inc == r_cnt)) begin
                        n_state = cdrs_pkg::S_WRAP;
                    end else begin
                        n_idx   = w_idx_inc;
                        n_state = cdrs_pkg::S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = cdrs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cdrs_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_first <= n_first;
        r_new   <= n_new;
        r_last  <= n_last;
        r_upper <= n_upper;
        r_pos   <= n_pos;
        r_total <= n_total;
        r_wrap  <= n_wrap;
        r_eor   <= n_eor;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rdata <= mem[w_raddr];
    end

    // register port: one head register at byte address 0
    assign w_cfg_wr = psel && penable && pwrite && pready && !paddr[cdrs_pkg::HEAD_SEL_BIT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
        end else if (w_cfg_wr) begin
            r_head <= pwdata[cdrs_pkg::TRK_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[cdrs_pkg::HEAD_SEL_BIT] ? '0 : cdrs_pkg::APB_DW'(r_head);

    assign o_ready          = (r_state == cdrs_pkg::S_IDLE);
    assign o_valid          = (r_state == cdrs_pkg::S_OUT);
    assign o_served_track   = cdrs_pkg::TRK_W'(r_pos);
    assign o_wrap_stop      = r_wrap;
    assign o_total_movement = r_total;
    assign o_end_of_run     = r_eor;

endmodule

### hdl/cdrs_checker.sv
// ----------------------------------------------------------------------------
// C-SCAN scheduler port checker
// Watches the item channels of the scheduler top level.
// ----------------------------------------------------------------------------
`include "cscan_disk_request_scheduler_defines.svh"

module cdrs_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_ready,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [cdrs_pkg::TRK_W-1:0]  o_served_track,
    input logic                        o_wrap_stop,
    input logic [cdrs_pkg::TOT_W-1:0]  o_total_movement,
    input logic                        o_end_of_run
);

    logic [cdrs_pkg::TRK_W+cdrs_pkg::TOT_W+1:0] w_payload;

    assign w_payload = {o_served_track, o_wrap_stop, o_total_movement, o_end_of_run};

    // a pending result holds until taken
    `CDRS_ASSERT_NXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(w_payload))

    // no new item is taken while a result is shown
    `CDRS_ASSERT_IMP(a_busy_excl, o_valid, !o_ready)

    // the wrap stop always lands on track 0
    `CDRS_ASSERT_IMP(a_wrap_zero, o_valid && o_wrap_stop, o_served_track == '0)

    // after the final visit the block is idle and ready again
    `CDRS_ASSERT_NXT(a_run_end, o_valid && i_ready && o_end_of_run, o_ready && !o_valid)

endmodule

bind cscan_disk_request_scheduler cdrs_checker u_cdrs_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_ready          (o_ready),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_served_track   (o_served_track),
    .o_wrap_stop      (o_wrap_stop),
    .o_total_movement (o_total_movement),
    .o_end_of_run     (o_end_of_run)
);

### dv/tb_cscan_disk_request_scheduler.sv
// ----------------------------------------------------------------------------
// C-SCAN scheduler testbench
// Streams track request batches into the scheduler and checks every visit
// it emits against a cycle-free predictor of the C-SCAN schedule. It starts
// with a table of directed batches and then runs random batches of random
// size, head position and track spread, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_cscan_disk_request_scheduler;

    localparam int REQ_DEPTH    = 32;
    localparam int ITEMS_TOTAL  = 370;
    localparam int DRAIN_CYCLES = 100;   // covers a full insertion pass
    localparam int STALL_LIMIT  = 4000;
    localparam int DIR_N        = 25;
    localparam logic [cdrs_pkg::APB_AW-1:0] HEAD_ADDR = '0;

    typedef struct packed {
        logic [cdrs_pkg::TRK_W-1:0] served;
        logic                       wrap;
        logic [cdrs_pkg::TOT_W-1:0] total;
        logic                       eor;
    } t_visit;

    typedef struct packed {
        logic                       new_head;
        logic [cdrs_pkg::TRK_W-1:0] head;
        logic [cdrs_pkg::TRK_W-1:0] track;
        logic                       is_last;
        logic                       chk;
        t_visit                     first;
    } t_dir_row;

    localparam t_visit NO_VISIT = '0;

    // first visit typed in only where it is obvious
    localparam t_dir_row DIR_TAB [DIR_N] = '{
        '{1'b0, 16'd0,     16'd0,     1'b1, 1'b1, '{16'd0,     1'b1, 18'd0,     1'b0}},
        '{1'b0, 16'd0,     16'd65535, 1'b1, 1'b1, '{16'd65535, 1'b0, 18'd65535, 1'b0}},
        '{1'b1, 16'd65535, 16'd65535, 1'b1, 1'b1, '{16'd0,     1'b1, 18'd65535, 1'b0}},
        '{1'b1, 16'd65535, 16'd0,     1'b1, 1'b1, '{16'd0,     1'b1, 18'd65535, 1'b0}},
        '{1'b0, 16'd0,     16'd40000, 1'b0, 1'b0, NO_VISIT},
        '{1'b0, 16'd0,     16'd65535, 1'b0, 1'b0, NO_VISIT},
        '{1'b0, 16'd0,     16'd0,     1'b0, 1'b0, NO_VISIT},
        '{1'b0, 16'd0,     16'd40000, 1'b1, 1'b1, '{16'd0,     1'b1, 18'd65535, 1'b0}},
        '{1'b1, 16'd1000,  16'd2000,  1'b0, 1'b0, NO_VISIT},
        '{1'b0, 16'd0,     16'd500,   1'b0, 1'b0, NO_VISIT},
        '{1'b0, 16'd0,     16'd1000,  1'b0, 1'b0, NO_VISIT},
        '{1'b0, 16'd0,     16'd3000,  1'b0, 1'b0, NO_VISIT},
        '{1'b0, 16'd0,     16'd1001,  1'b0, 1'b0, NO_VISIT},
        '{1'b0, 16'd0,     16'd999,   1'b1, 1'b1, '{16'd1001,  1'b0, 18'd1,     1'b0}},
        '{1'b1, 16'd7,     16'd7,     1'b0, 1'b0, NO_VISIT},
        '{1'b0, 16'd0,     16'd7,     1'b0, 1'b0, NO_VISIT},
        '{1'b0, 16'd0,     16'd7,     1'b1, 1'b1, '{16'd0,     1'b1, 18'd7,     1'b0}},
        '{1'b1, 16'd0,     16'd9,     1'b0, 1'b0, NO_VISIT},
        '{1'b0, 16'd0,     16'd3,     1'b0, 1'b0, NO_VISIT},
        '{1'b0, 16'd0,     16'd65535, 1'b0, 1'b0, NO_VISIT},
        '{1'b0, 16'd0,     16'd1,     1'b1, 1'b1, '{16'd1,     1'b0, 18'd1,     1'b0}},
        '{1'b1, 16'd32768, 16'd32767, 1'b1, 1'b1, '{16'd0,     1'b1, 18'd32768, 1'b0}},
        '{1'b0, 16'd0,     16'd32769, 1'b1, 1'b1, '{16'd32769, 1'b0, 18'd1,     1'b0}},
        '{1'b1, 16'h5555,  16'hAAAA,  1'b0, 1'b0, NO_VISIT},
        '{1'b0, 16'd0,     16'h5555,  1'b1, 1'b1, '{16'hAAAA,  1'b0, 18'd21845, 1'b0}}
    };

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_ready;
    logic [cdrs_pkg::TRK_W-1:0]  i_track;
    logic                        i_last;
    logic                        o_valid;
    logic                        i_ready;
    logic [cdrs_pkg::TRK_W-1:0]  o_served_track;
    logic                        o_wrap_stop;
    logic [cdrs_pkg::TOT_W-1:0]  o_total_movement;
    logic                        o_end_of_run;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [cdrs_pkg::APB_AW-1:0] paddr;
    logic [cdrs_pkg::APB_DW-1:0] pwdata;
    logic [cdrs_pkg::APB_DW-1:0] prdata;
    logic                        pready;

    cscan_disk_request_scheduler #(
        .MAX_REQUESTS(REQ_DEPTH),
        .TRACK_BITS  (cdrs_pkg::TRK_W)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_track         (i_track),
        .i_last          (i_last),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_served_track  (o_served_track),
        .o_wrap_stop     (o_wrap_stop),
        .o_total_movement(o_total_movement),
        .o_end_of_run    (o_end_of_run),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // predictor state
    logic [cdrs_pkg::TRK_W-1:0] head_reg;
    logic [cdrs_pkg::TRK_W-1:0] req_q [$];
    t_visit                     batch_plan [$];
    t_visit                     visit_q [$];
    t_visit                     got_v;

    int  n_errors  = 0;
    int  n_sent    = 0;
    int  n_batches = 0;
    int  n_visits  = 0;
    int  n_heads   = 0;
    int  rx_hold   = 0;
    int  idle_run  = 0;
    bit  quiet     = 0;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic flag_error(input string msg);
        if (n_errors < 30) $display("ERROR @%0t: %s", $time, msg);
        n_errors++;
    endtask

    // store the request, and on the closing one build the C-SCAN visit list
    function automatic void take_request(input logic [cdrs_pkg::TRK_W-1:0] trk,
                                         input logic is_last);
        logic [cdrs_pkg::TRK_W-1:0] sorted [$];
        logic [cdrs_pkg::TRK_W-1:0] pos;
        int unsigned                total;
        int                         first_up;
        bit                         found;
        if (req_q.size() < REQ_DEPTH) req_q.push_back(trk);
        if (!is_last) return;
        sorted = req_q;
        sorted.sort();
        first_up = sorted.size();
        found = 0;
        foreach (sorted[i]) begin
            if (!found && sorted[i] > head_reg) begin
                first_up = i;
                found = 1;
            end
        end
        batch_plan.delete();
        pos = head_reg;
        total = 0;
        for (int i = first_up; i < sorted.size(); i++) begin
            total += sorted[i] - pos;
            pos = sorted[i];
            batch_plan.push_back(t_visit'{pos, 1'b0, total[cdrs_pkg::TOT_W-1:0], 1'b0});
        end
        total += pos;
        pos = '0;
        batch_plan.push_back(t_visit'{'0, 1'b1, total[cdrs_pkg::TOT_W-1:0], first_up == 0});
        for (int i = 0; i < first_up; i++) begin
            total += sorted[i] - pos;
            pos = sorted[i];
            batch_plan.push_back(t_visit'{pos, 1'b0, total[cdrs_pkg::TOT_W-1:0],
                                          i + 1 == first_up});
        end
        foreach (batch_plan[i]) visit_q.push_back(batch_plan[i]);
        req_q.delete();
        n_batches++;
    endfunction

    task automatic send_item(input logic [cdrs_pkg::TRK_W-1:0] trk, input logic is_last);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_track <= trk;
        i_last  <= is_last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        take_request(trk, is_last);
        n_sent++;
    endtask

    // sender goes quiet until every visit is out and the block is idle
    task automatic settle();
        i_valid <= 1'b0;
        while (visit_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // write the head register, then read it back
    task automatic program_head(input logic [cdrs_pkg::TRK_W-1:0] head);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= HEAD_ADDR;
        pwdata  <= {16'($urandom), head};   // upper bits are don't care
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        head_reg = head;
        n_heads++;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== cdrs_pkg::APB_DW'(head))
            flag_error($sformatf("head readback %0h, expected %0h", prdata, head));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // result side: random stall after each item
    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            if (rx_hold == 0) i_ready <= 1'b1;
        end else if (o_valid && i_ready) begin
            rx_hold = quiet ? 0 : $urandom_range(0, 15);
            if (rx_hold > 0) i_ready <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (visit_q.size() == 0) begin
                flag_error($sformatf("visit to track %0d with none expected", o_served_track));
            end else begin
                got_v = visit_q.pop_front();
                if (o_served_track !== got_v.served)
                    flag_error($sformatf("served_track %0d, expected %0d",
                                         o_served_track, got_v.served));
                if (o_wrap_stop !== got_v.wrap)
                    flag_error($sformatf("wrap_stop %b, expected %b", o_wrap_stop, got_v.wrap));
                if (o_total_movement !== got_v.total)
                    flag_error($sformatf("total_movement %0d, expected %0d",
                                         o_total_movement, got_v.total));
                if (o_end_of_run !== got_v.eor)
                    flag_error($sformatf("end_of_run %b, expected %b", o_end_of_run, got_v.eor));
                n_visits++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || psel || !i_rst_n) begin
            idle_run = 0;
        end else begin
            idle_run++;
            if (idle_run >= STALL_LIMIT) begin
                $display("timeout: no handshake for %0d cycles, %0d visits pending",
                         idle_run, visit_q.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        int                         len;
        int                         spread;
        bit                         first_batch;
        logic [cdrs_pkg::TRK_W-1:0] trk;
        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_track  = '0;
        i_last   = 1'b0;
        i_ready  = 1'b1;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        head_reg = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table; first batch runs on the reset head value
        for (int r = 0; r < DIR_N; r++) begin
            if (DIR_TAB[r].new_head) begin
                settle();
                program_head(DIR_TAB[r].head);
            end
            send_item(DIR_TAB[r].track, DIR_TAB[r].is_last);
            if (DIR_TAB[r].chk && batch_plan[0] != DIR_TAB[r].first)
                flag_error($sformatf("table row %0d: first visit %p, expected %p",
                                     r, batch_plan[0], DIR_TAB[r].first));
        end

        // random batches; the first one overflows the store
        first_batch = 1;
        while (n_sent < ITEMS_TOTAL) begin
            quiet = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: len = $urandom_range(1, 6);
                6, 7:             len = $urandom_range(7, 16);
                8:                len = $urandom_range(17, REQ_DEPTH);
                default:          len = $urandom_range(REQ_DEPTH + 1, REQ_DEPTH + 4);
            endcase
            if (first_batch) len = REQ_DEPTH + 2;
            if (first_batch || $urandom_range(0, 2) == 0) begin
                settle();
                case ($urandom_range(0, 3))
                    0:       program_head('0);
                    1:       program_head('1);
                    default: program_head(16'($urandom));
                endcase
            end else if ($urandom_range(0, 5) == 0) begin
                settle();
            end
            spread = $urandom_range(0, 2);
            for (int k = 0; k < len; k++) begin
                case (spread)
                    0: trk = 16'($urandom);
                    1: trk = head_reg + 16'($urandom_range(0, 64)) - 16'd32;
                    default: begin
                        case ($urandom_range(0, 5))
                            0:       trk = '0;
                            1:       trk = '1;
                            2:       trk = head_reg;
                            3:       trk = head_reg + 16'd1;
                            4:       trk = head_reg - 16'd1;
                            default: trk = 16'($urandom);
                        endcase
                    end
                endcase
                send_item(trk, k == len - 1);
            end
            first_batch = 0;
        end

        quiet = 0;
        settle();
        if (visit_q.size() != 0)
            flag_error($sformatf("%0d visits never arrived", visit_q.size()));
        $display("run covered %0d requests in %0d batches under %0d head settings",
                 n_sent, n_batches, n_heads);
        $display("%0d visits checked, %0d mismatches", n_visits, n_errors);
        if (n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
